/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is low.
`define FLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define FLS_NEVER(lbl, cond, msg) \
  `FLS_ASSERT(lbl, !(cond), msg)

`endif

/* design/fls_pkg.sv */
// Package for the free-list slot allocator: sizes, codes and types.
`timescale 1ns / 1ps
package fls_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 9;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXHAUSTED    = 2'd1,
    ST_NOT_IN_USE   = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    logic              mark;
    logic [SLOT_W-1:0] link;
  } slot_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    status_e           status;
    logic [CNT_W-1:0]  slots_in_use;
  } rsp_t;

endpackage

/* design/fls_ifs.sv */
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps
interface fls_req_if;
  logic                        valid;
  logic                        ready;
  fls_pkg::op_e                opcode;
  logic [fls_pkg::SLOT_W-1:0]  slot_index;
  modport source (output valid, opcode, slot_index, input ready);
  modport sink   (input valid, opcode, slot_index, output ready);
endinterface

interface fls_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fls_pkg::SLOT_W-1:0]  granted_slot;
  fls_pkg::status_e            status;
  logic [fls_pkg::CNT_W-1:0]   slots_in_use;
  modport source (output valid, granted_slot, status, slots_in_use, input ready);
  modport sink   (input valid, granted_slot, status, slots_in_use, output ready);
endinterface

interface fls_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fls_pkg::CNT_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/free_list_slot_allocator_top.sv */
// Top level of the free-list slot allocator.
//
//  channel  dir  signals                                   transaction
//  req_i    in   valid ready opcode slot_index             one operation
//  rsp_o    out  valid ready granted_slot status slots_in_use  one result
//  cfg_i    in   valid ready data                          pool_size write
//
//  An operation first reads the slot word (mark + link) from the slot RAM,
//  then decides, writes the word back and loads the result. The single
//  RAM port pair limits the block to one operation in flight. Reset and
//  rebuild clear a per-slot valid vector, so no clearing pass runs; an
//  invalid slot reads as unmarked, linking to i+1. A held result stalls
//  only the decide step; the result register lets the next operation
//  enter while the previous result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module free_list_slot_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  fls_req_if.sink    req_i,
  fls_rsp_if.source  rsp_o,
  fls_cfg_if.sink    cfg_i
);
  import fls_pkg::*;

  fsm_e              state_q, state_d;
  op_e               op_q;
  logic [SLOT_W-1:0] addr_q;      // slot read when the operation is accepted
  logic              hit_q;       // valid bit of that slot
  logic [CNT_W-1:0]  pool_q;      // written size, used at next rebuild
  logic [CNT_W-1:0]  act_q, act_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [SLOTS-1:0]  vld_q;
  rsp_t              rsp_q, rsp_d;
  logic              out_vld_q;

  logic              accept, finish, clear_vld;
  logic              we;
  slot_word_t        wdata, rdata, word;
  logic [SLOT_W-1:0] raddr;

  function automatic logic [CNT_W-1:0] clamp_size(logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > CNT_W'(SLOTS)) begin
      return CNT_W'(SLOTS);
    end
    return v;
  endfunction

  assign req_i.ready = (state_q == FSM_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign finish      = (state_q == FSM_EXEC) && (!out_vld_q || rsp_o.ready);
  assign raddr       = (req_i.opcode == OP_FREE) ? req_i.slot_index : head_q;

  // Slot never written since rebuild: free, linked to the next index.
  assign word = hit_q ? rdata : slot_word_t'{mark: 1'b0, link: addr_q + SLOT_W'(1)};

  fls_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    head_d    = head_q;
    used_d    = used_q;
    we        = 1'b0;
    wdata     = word;
    clear_vld = 1'b0;
    rsp_d     = rsp_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (finish) begin
          state_d            = FSM_IDLE;
          rsp_d.granted_slot = '0;
          rsp_d.status       = ST_OK;
          unique case (op_q)
            OP_ALLOC: begin
              if (used_q >= act_q) begin
                rsp_d.status = ST_EXHAUSTED;
              end else begin
                rsp_d.granted_slot = head_q;
                we                 = 1'b1;
                wdata              = '{mark: 1'b1, link: word.link};
                head_d             = word.link;
                used_d             = used_q + CNT_W'(1);
              end
            end
            OP_FREE: begin
              if ({1'b0, addr_q} >= act_q) begin
                rsp_d.status = ST_OUT_OF_RANGE;
              end else if (!word.mark) begin
                rsp_d.status = ST_NOT_IN_USE;
              end else begin
                we     = 1'b1;
                wdata  = '{mark: 1'b0, link: head_q};
                head_d = addr_q;
                if (used_q != '0) begin
                  used_d = used_q - CNT_W'(1);
                end
              end
            end
            OP_REBUILD: begin
              act_d     = clamp_size(pool_q);
              clear_vld = 1'b1;
              head_d    = '0;
              used_d    = '0;
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
          rsp_d.slots_in_use = used_d;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      pool_q    <= CNT_W'(SLOTS);
      act_q     <= CNT_W'(SLOTS);
      head_q    <= '0;
      used_q    <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      head_q  <= head_d;
      used_q  <= used_d;
      if (cfg_i.valid) begin
        pool_q <= cfg_i.data;
      end
      if (clear_vld) begin
        vld_q <= '0;
      end else if (we) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Operation payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.opcode;
      addr_q <= raddr;
      hit_q  <= vld_q[raddr];
    end
    rsp_q <= rsp_d;
  end

  assign cfg_i.ready        = 1'b1;
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.granted_slot = rsp_q.granted_slot;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.slots_in_use = rsp_q.slots_in_use;

  `FLS_ASSERT(a_count_le_size, used_q <= act_q, "allocated count above pool size")
  `FLS_NEVER(a_no_accept_busy, (state_q == FSM_EXEC) && req_i.ready, "accept while busy")
  `FLS_ASSERT(a_grant_in_range, rsp_o.valid |-> ({1'b0, rsp_o.granted_slot} < act_q), "grant out of range")
  `FLS_ASSERT(a_exhausted_full, (rsp_o.valid && rsp_o.status == ST_EXHAUSTED) |-> (rsp_o.slots_in_use == act_q), "exhausted but not full")

endmodule

/* design/fls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fls_ram #(
  parameter int WIDTH  = 9,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* tb/free_list_slot_allocator_top_test.sv */
// Testbench for the free-list slot allocator: directed and random operations against a pool model.
`timescale 1ns / 1ps
module free_list_slot_allocator_top_test;
  import fls_pkg::*;

  // Run-time limit, set with wide margin over a correct run.
  localparam int CYCLE_LIMIT  = 400000;
  // Drain time at the end: one operation in flight plus one held result.
  localparam int DRAIN_CYCLES = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fls_req_if req_if ();
  fls_rsp_if rsp_if ();
  fls_cfg_if cfg_if ();

  free_list_slot_allocator_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pool model: LIFO free list with per-slot marks, tracked per accepted
  // transaction. The size register only reaches the live size at a rebuild.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  size_reg;
  logic [CNT_W-1:0]  live_size;
  logic [SLOT_W-1:0] head_slot;
  logic [SLOT_W-1:0] link_mem [SLOTS];
  logic              busy_mark [SLOTS];
  logic [CNT_W-1:0]  busy_count;

  rsp_t awaited_rsp [$];   // expected responses, oldest first

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;   // percent of cycles the request side holds back
  int recv_idle_pct = 0;   // percent of cycles the response side stalls
  int hold_left     = 0;   // long response stall, counted down per cycle

  // Size 0 behaves as 1, anything above the built depth as the full depth.
  function automatic void rebuild_pool();
    if (size_reg == '0) begin
      live_size = CNT_W'(1);
    end else if (size_reg > SLOTS) begin
      live_size = CNT_W'(SLOTS);
    end else begin
      live_size = size_reg;
    end
    for (int i = 0; i < SLOTS; i++) begin
      link_mem[i]  = SLOT_W'(i + 1);   // last slot wraps to 0
      busy_mark[i] = 1'b0;
    end
    head_slot  = '0;
    busy_count = '0;
  endfunction

  function automatic rsp_t apply_pool_op(op_e op, logic [SLOT_W-1:0] slot);
    rsp_t r;
    r.granted_slot = '0;
    r.status       = ST_OK;
    case (op)
      OP_ALLOC: begin
        if (busy_count >= live_size) begin
          r.status = ST_EXHAUSTED;
        end else begin
          r.granted_slot      = head_slot;
          busy_mark[head_slot] = 1'b1;
          head_slot           = link_mem[head_slot];
          busy_count          = busy_count + CNT_W'(1);
        end
      end
      OP_FREE: begin
        // range check wins over the mark check
        if (CNT_W'(slot) >= live_size) begin
          r.status = ST_OUT_OF_RANGE;
        end else if (!busy_mark[slot]) begin
          r.status = ST_NOT_IN_USE;
        end else begin
          busy_mark[slot] = 1'b0;
          link_mem[slot]  = head_slot;
          head_slot       = slot;
          if (busy_count != '0) busy_count = busy_count - CNT_W'(1);
        end
      end
      OP_REBUILD: rebuild_pool();
      default: ;   // unused opcode: no change, ok status
    endcase
    r.slots_in_use = busy_count;
    return r;
  endfunction

  // A slot currently handed out, from a random starting point; random if none.
  function automatic logic [SLOT_W-1:0] pick_busy_slot();
    int start;
    int idx;
    start = $urandom_range(int'(live_size) - 1);
    for (int k = 0; k < int'(live_size); k++) begin
      idx = (start + k) % int'(live_size);
      if (busy_mark[idx]) return SLOT_W'(idx);
    end
    return SLOT_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls, plus a long hold-off when asked for.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Each response transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("unexpected response, slots_in_use", int'(rsp_if.slots_in_use), -1);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_if.granted_slot !== want.granted_slot)
          report_mismatch("granted_slot", int'(rsp_if.granted_slot), int'(want.granted_slot));
        if (rsp_if.status !== want.status)
          report_mismatch("status", int'(rsp_if.status), int'(want.status));
        if (rsp_if.slots_in_use !== want.slots_in_use)
          report_mismatch("slots_in_use", int'(rsp_if.slots_in_use), int'(want.slots_in_use));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Called at a falling edge, returns at a falling edge with
  // valid still high, so back-to-back transactions never toggle valid.
  // ---------------------------------------------------------------------------
  task automatic send_op(op_e op, logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.slot_index <= slot;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    awaited_rsp.push_back(apply_pool_op(op, slot));
    @(negedge clk_i);
  endtask

  // Register write only once every response is back; the block is then idle.
  task automatic write_pool_size(logic [CNT_W-1:0] value);
    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    size_reg = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // New size only takes hold at the rebuild.
  task automatic resize_pool(logic [CNT_W-1:0] value);
    write_pool_size(value);
    send_op(OP_REBUILD, SLOT_W'($urandom));
  endtask

  // Mostly well-formed traffic (allocs and frees of granted slots), with
  // some bad frees, unused opcodes and rebuilds mixed in.
  task automatic run_random(int count, int alloc_pct, int rebuild_pct);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < rebuild_pct) begin
        send_op(OP_REBUILD, SLOT_W'($urandom));
      end else if (roll < rebuild_pct + 3) begin
        send_op(OP_NOP, SLOT_W'($urandom));
      end else if (roll < rebuild_pct + 7) begin
        send_op(OP_FREE, SLOT_W'($urandom));
      end else if (roll < rebuild_pct + 11) begin
        send_op(OP_FREE, SLOT_W'($urandom_range(int'(live_size) - 1)));
      end else if (roll < rebuild_pct + 11 + alloc_pct) begin
        send_op(OP_ALLOC, SLOT_W'($urandom));
      end else begin
        send_op(OP_FREE, pick_busy_slot());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pool as left by reset: LIFO reuse, double free, free of a never-used slot.
  task automatic test_reset_state();
    send_op(OP_ALLOC, 8'hff);
    send_op(OP_ALLOC, 8'h00);
    send_op(OP_ALLOC, 8'h5a);
    send_op(OP_FREE, 8'd1);
    send_op(OP_ALLOC, 8'h00);     // gets slot 1 back
    send_op(OP_FREE, 8'd1);
    send_op(OP_FREE, 8'd1);       // already free
    send_op(OP_FREE, 8'd255);     // in range, never handed out
    send_op(OP_NOP, 8'd255);
    send_op(OP_FREE, 8'd0);
    send_op(OP_FREE, 8'd2);
    send_op(OP_ALLOC, 8'h00);     // most recent free first
    send_op(OP_REBUILD, 8'ha5);
    send_op(OP_ALLOC, 8'h00);
  endtask

  // Size 0 acts as 1, oversize acts as full depth, write waits for rebuild.
  task automatic test_size_limits();
    resize_pool('0);
    send_op(OP_ALLOC, 8'h00);
    send_op(OP_ALLOC, 8'h00);     // exhausted
    send_op(OP_FREE, 8'd1);       // out of range
    send_op(OP_FREE, 8'd255);     // out of range
    send_op(OP_FREE, 8'd0);
    send_op(OP_FREE, 8'd0);       // not in use
    write_pool_size(9'h1ff);
    send_op(OP_ALLOC, 8'h00);
    send_op(OP_ALLOC, 8'h00);     // still size 1 until the rebuild
    send_op(OP_REBUILD, 8'h00);
    send_op(OP_FREE, 8'd255);
    send_op(OP_ALLOC, 8'h00);
  endtask

  task automatic test_random_small_pools();
    resize_pool(9'd2);
    run_random(150, 50, 3);
    resize_pool(9'd37);
    run_random(200, 50, 2);
  endtask

  // Fill the full-depth pool to exhaustion, then drain part of it.
  task automatic test_full_pool();
    resize_pool(9'd256);
    run_random(400, 80, 0);
    run_random(150, 15, 0);
  endtask

  // Long response stall while requests keep coming: input must back up.
  task automatic test_backpressure();
    hold_left = 300;
    run_random(40, 50, 0);
  endtask

  task automatic test_mixed_sizes();
    resize_pool(9'd170);
    run_random(250, 55, 2);
    resize_pool(9'd85);
    run_random(200, 45, 2);
  endtask

  initial begin
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_ALLOC;
    req_if.slot_index = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    rsp_if.ready      = 1'b0;

    size_reg = 9'd256;
    rebuild_pool();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender rarely idle, receiver mostly stalled
    send_idle_pct = 11;
    recv_idle_pct = 86;
    test_reset_state();
    test_size_limits();
    test_random_small_pools();

    // the other way round
    send_idle_pct = 86;
    recv_idle_pct = 11;
    test_full_pool();
    test_backpressure();

    // no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_mixed_sizes();

    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
